>>> rtl/icer_pkg.sv
// Package for the ICMPv6 echo responder: header offsets, protocol constants,
// mode codes and the address remap and checksum patch functions.
// No dependencies.
package icer_pkg;

	// Header geometry
	localparam int unsigned HDR_LEN = 62;
	localparam int unsigned POS_W   = 6;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [7:0]       byte_t;
	typedef logic [15:0]      word_t;

	localparam pos_t HDR_END      = 6'd61;
	localparam pos_t MAC_LEN      = 6'd6;
	localparam pos_t POS_ETYPE_HI = 6'd12;
	localparam pos_t POS_ETYPE_LO = 6'd13;
	localparam pos_t POS_NEXTHDR  = 6'd20;
	localparam pos_t POS_SRC_IP   = 6'd22;
	localparam pos_t POS_DST_IP   = 6'd38;
	localparam pos_t IP_ALEN      = 6'd16;
	localparam pos_t POS_TYPE     = 6'd54;
	localparam pos_t POS_CSUM_HI  = 6'd56;
	localparam pos_t POS_CSUM_LO  = 6'd57;

	// Protocol constants
	localparam byte_t ETH_P_IPV6_HI     = 8'h86;
	localparam byte_t ETH_P_IPV6_LO     = 8'hDD;
	localparam byte_t NH_ICMP6          = 8'd58;
	localparam byte_t ECHO_REQ_TYPE     = 8'd128;
	localparam byte_t ECHO_REP_TYPE     = 8'd129;
	localparam word_t ECHO_REQUEST_WORD = {ECHO_REQ_TYPE, 8'h00};
	localparam word_t ECHO_REPLY_WORD   = {ECHO_REP_TYPE, 8'h00};

	// Frame mode codes
	localparam logic [1:0] MODE_COLLECT = 2'd0;
	localparam logic [1:0] MODE_PASS    = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;
	localparam logic [1:0] MODE_BURST   = 2'd3;

	// Header store address that feeds reply byte i (MAC and IPv6 address swap)
	function automatic pos_t src_addr(input pos_t i);
		pos_t a;
		a = i;
		if (i < MAC_LEN) begin
			a = i + MAC_LEN;
		end else if (i < (MAC_LEN + MAC_LEN)) begin
			a = i - MAC_LEN;
		end else if (i >= POS_SRC_IP && i < POS_DST_IP) begin
			a = i + IP_ALEN;
		end else if (i >= POS_DST_IP && i < POS_TYPE) begin
			a = i - IP_ALEN;
		end
		return a;
	endfunction

	// One's complement add with end-around carry
	function automatic word_t ones_add(input word_t a, input word_t b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Incremental checksum update for the type change
	function automatic word_t csum_patch(input word_t cs);
		word_t t;
		t = ones_add(~cs, ~ECHO_REQUEST_WORD);
		return ~ones_add(t, ECHO_REPLY_WORD);
	endfunction

endpackage

>>> rtl/icer_if.sv
// Handshake interfaces for the echo responder: input byte channel and
// result channel, each with valid, ready and payload. No dependencies.
interface icer_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
	modport mon    (input valid, ready, in_byte, in_last);
endinterface

interface icer_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       frame_dropped;

	modport source (output valid, out_byte, out_last, frame_dropped, input ready);
	modport sink   (input valid, out_byte, out_last, frame_dropped, output ready);
	modport mon    (input valid, ready, out_byte, out_last, frame_dropped);
endinterface

>>> rtl/icer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
// data that holds while no read is issued. No dependencies.
module icer_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/icmpv6_echo_responder_core.sv
// Channel   Dir  Payload                              Handshake
// in_ch     in   in_byte[7:0], in_last                valid/ready
// out_ch    out  out_byte[7:0], out_last, frame_dropped valid/ready
//
// Header bytes and payload bytes are taken one per cycle while the result side
// does not stall. When the 62nd header byte is accepted and the checks pass, a
// 62-byte reply burst is read from the header RAM, one byte per cycle while the
// output register is free; input is held off for the whole burst.
// Reset leaves the block collecting a new header; the header RAM needs no clear.
// A stall on the result side holds the output register and stops the input.
// Depends on icer_pkg, icer_if and icer_ram.
module icmpv6_echo_responder_core (
	input  logic              clk,
	input  logic              arst_n,
	icer_in_if.sink           in_ch,
	icer_out_if.source        out_ch
);

	logic [1:0]         mode_q;
	icer_pkg::pos_t     pos_q;
	logic               et_hi_ok_q, et_lo_ok_q, nh_ok_q, type_ok_q;
	icer_pkg::word_t    cs_q;
	icer_pkg::word_t    cs_new;
	logic               burst_last_q;
	icer_pkg::pos_t     rd_idx_q;
	logic               rd_done_q;
	logic               pend_q;
	icer_pkg::pos_t     idx_s1;
	logic               out_valid_q;
	icer_pkg::byte_t    out_byte_q;
	logic               out_last_q;
	logic               out_drop_q;

	logic               out_free, acc, load, issue, hdr_ok, ram_we;
	icer_pkg::byte_t    rdata;
	icer_pkg::byte_t    reply_byte;

	// Handshake and control strobes
	always_comb begin
		out_free    = !out_valid_q || out_ch.ready;
		in_ch.ready = (mode_q != icer_pkg::MODE_BURST) && out_free;
		acc         = in_ch.valid && in_ch.ready;
		load        = pend_q && out_free;
		issue       = (mode_q == icer_pkg::MODE_BURST) && !rd_done_q && (!pend_q || load);
		ram_we      = acc && (mode_q == icer_pkg::MODE_COLLECT);
		hdr_ok      = et_hi_ok_q && et_lo_ok_q && nh_ok_q && type_ok_q;
	end

	icer_ram #(
		.WIDTH (8),
		.DEPTH (icer_pkg::HDR_LEN)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (in_ch.in_byte),
		.re    (issue),
		.raddr (icer_pkg::src_addr(rd_idx_q)),
		.rdata (rdata)
	);

	// Patch type and checksum on the way out
	always_comb begin
		cs_new = icer_pkg::csum_patch(cs_q);
		case (idx_s1)
			icer_pkg::POS_TYPE:    reply_byte = icer_pkg::ECHO_REP_TYPE;
			icer_pkg::POS_CSUM_HI: reply_byte = cs_new[15:8];
			icer_pkg::POS_CSUM_LO: reply_byte = cs_new[7:0];
			default:               reply_byte = rdata;
		endcase
	end

	// Capture header fields for the checks as they pass
	always_ff @(posedge clk) begin
		if (ram_we) begin
			case (pos_q)
				icer_pkg::POS_ETYPE_HI: et_hi_ok_q <= in_ch.in_byte == icer_pkg::ETH_P_IPV6_HI;
				icer_pkg::POS_ETYPE_LO: et_lo_ok_q <= in_ch.in_byte == icer_pkg::ETH_P_IPV6_LO;
				icer_pkg::POS_NEXTHDR:  nh_ok_q    <= in_ch.in_byte == icer_pkg::NH_ICMP6;
				icer_pkg::POS_TYPE:     type_ok_q  <= in_ch.in_byte == icer_pkg::ECHO_REQ_TYPE;
				icer_pkg::POS_CSUM_HI:  cs_q[15:8] <= in_ch.in_byte;
				icer_pkg::POS_CSUM_LO:  cs_q[7:0]  <= in_ch.in_byte;
				default: ;
			endcase
		end
	end

	// Frame mode, position and burst read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= icer_pkg::MODE_COLLECT;
			pos_q        <= '0;
			rd_idx_q     <= '0;
			rd_done_q    <= 1'b0;
			pend_q       <= 1'b0;
			burst_last_q <= 1'b0;
		end else begin
			if (acc) begin
				case (mode_q)
					icer_pkg::MODE_PASS, icer_pkg::MODE_DISCARD: begin
						if (in_ch.in_last) begin
							mode_q <= icer_pkg::MODE_COLLECT;
							pos_q  <= '0;
						end
					end
					default: begin
						if (pos_q == icer_pkg::HDR_END) begin
							pos_q <= '0;
							if (!hdr_ok) begin
								mode_q <= in_ch.in_last ? icer_pkg::MODE_COLLECT
								                        : icer_pkg::MODE_DISCARD;
							end else begin
								mode_q       <= icer_pkg::MODE_BURST;
								burst_last_q <= in_ch.in_last;
								rd_idx_q     <= '0;
								rd_done_q    <= 1'b0;
							end
						end else if (in_ch.in_last) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				endcase
			end
			// Advance the burst read index
			if (issue) begin
				if (rd_idx_q == icer_pkg::HDR_END) begin
					rd_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			pend_q <= issue ? 1'b1 : (load ? 1'b0 : pend_q);
			// Leave the burst once the final header byte is in the output register
			if (load && idx_s1 == icer_pkg::HDR_END) begin
				mode_q <= burst_last_q ? icer_pkg::MODE_COLLECT : icer_pkg::MODE_PASS;
			end
		end
	end

	// Track the header index of the read in flight
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
	end

	// Output register; a complete header decides on the checks, not on in_last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (acc && (mode_q == icer_pkg::MODE_PASS ||
		            ((mode_q == icer_pkg::MODE_COLLECT) &&
		             ((pos_q == icer_pkg::HDR_END) ? !hdr_ok : in_ch.in_last)))) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= reply_byte;
			out_last_q <= burst_last_q && (idx_s1 == icer_pkg::HDR_END);
			out_drop_q <= 1'b0;
		end else if (acc && mode_q == icer_pkg::MODE_PASS) begin
			out_byte_q <= in_ch.in_byte;
			out_last_q <= in_ch.in_last;
			out_drop_q <= 1'b0;
		end else if (acc) begin
			// Drop result for short or failed frames
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_drop_q <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.out_last      = out_last_q;
	assign out_ch.frame_dropped = out_drop_q;

endmodule

>>> rtl/icer_checker.sv
// Port-level checks for the echo responder, bound to the top level.
// Depends on icmpv6_echo_responder_core through the bind below, which picks the signals off the channel ports.
module icer_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_drop
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_last) && $stable(out_drop))
		else $error("result changed while stalled");

	// A drop result is a single zero byte that closes the frame
	a_drop_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_drop |-> out_byte == 8'd0 && out_last)
		else $error("malformed drop result");

	// Input stalls while a result waits
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

endmodule

bind icmpv6_echo_responder_core icer_checker u_icer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.out_last),
	.out_drop  (out_ch.frame_dropped)
);

>>> tb/tb.sv
// Testbench for icmpv6_echo_responder_core: sends directed and random Ethernet
// frames, predicts every reply byte and drop, and checks each result in order.
// Depends on icer_pkg, the icer_if interfaces and the responder RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		icer_pkg::byte_t data;
		logic            last;
		logic            drop;
	} reply_t;

	typedef enum int {
		FK_ECHO,
		FK_BAD_CHECK,
		FK_SHORT,
		FK_NOISE
	} frame_kind_t;

	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n;

	icer_in_if  in_ch ();
	icer_out_if out_ch ();

	icmpv6_echo_responder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Expected replies and the predictor's own copy of the block state
	reply_t          reply_q[$];
	icer_pkg::byte_t hdr_mem [icer_pkg::HDR_LEN];
	int unsigned     hdr_cnt      = 0;
	logic [1:0]      frame_state  = icer_pkg::MODE_COLLECT;

	int unsigned err_count    = 0;
	int unsigned sent_bytes   = 0;
	int unsigned in_idle_pct  = 13;
	int unsigned out_idle_pct = 84;
	int unsigned quiet_cycles = 0;
	logic        hold_req     = 1'b0;
	logic        hold_seen    = 1'b0;
	int unsigned hold_left    = 0;

	// Clock: 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One's complement sum, end-around carry folded back in
	function automatic icer_pkg::word_t oc_sum(input icer_pkg::word_t a,
	                                           input icer_pkg::word_t b);
		icer_pkg::word_t r;
		r = a + b;
		if (r < b) begin
			r = r + 16'd1;
		end
		return r;
	endfunction

	function automatic void push_reply(input icer_pkg::byte_t data, input logic last,
	                                   input logic drop);
		reply_t r;
		r.data = data;
		r.last = last;
		r.drop = drop;
		reply_q.push_back(r);
	endfunction

	// Work out the results caused by one accepted input item
	function automatic void predict_reply(input icer_pkg::byte_t b, input logic last);
		icer_pkg::byte_t t;
		icer_pkg::word_t cs;
		case (frame_state)
			icer_pkg::MODE_PASS: begin
				push_reply(b, last, 1'b0);
				if (last) begin
					frame_state = icer_pkg::MODE_COLLECT;
					hdr_cnt     = 0;
				end
			end
			icer_pkg::MODE_DISCARD: begin
				if (last) begin
					frame_state = icer_pkg::MODE_COLLECT;
					hdr_cnt     = 0;
				end
			end
			default: begin
				if (hdr_cnt >= icer_pkg::HDR_LEN) begin
					hdr_cnt = 0;
				end
				hdr_mem[hdr_cnt] = b;
				hdr_cnt++;
				if (hdr_cnt < icer_pkg::HDR_LEN) begin
					// short frame: drop and start over
					if (last) begin
						push_reply(8'h00, 1'b1, 1'b1);
						hdr_cnt     = 0;
						frame_state = icer_pkg::MODE_COLLECT;
					end
				end else begin
					hdr_cnt = 0;
					if (hdr_mem[icer_pkg::POS_ETYPE_HI] != icer_pkg::ETH_P_IPV6_HI ||
					    hdr_mem[icer_pkg::POS_ETYPE_LO] != icer_pkg::ETH_P_IPV6_LO ||
					    hdr_mem[icer_pkg::POS_NEXTHDR] != icer_pkg::NH_ICMP6 ||
					    hdr_mem[icer_pkg::POS_TYPE] != icer_pkg::ECHO_REQ_TYPE) begin
						push_reply(8'h00, 1'b1, 1'b1);
						frame_state = last ? icer_pkg::MODE_COLLECT : icer_pkg::MODE_DISCARD;
					end else begin
						// swap MACs and IPv6 addresses, turn request into reply
						for (int i = 0; i < int'(icer_pkg::MAC_LEN); i++) begin
							t = hdr_mem[i];
							hdr_mem[i] = hdr_mem[i + int'(icer_pkg::MAC_LEN)];
							hdr_mem[i + int'(icer_pkg::MAC_LEN)] = t;
						end
						for (int i = 0; i < int'(icer_pkg::IP_ALEN); i++) begin
							t = hdr_mem[int'(icer_pkg::POS_SRC_IP) + i];
							hdr_mem[int'(icer_pkg::POS_SRC_IP) + i] =
								hdr_mem[int'(icer_pkg::POS_DST_IP) + i];
							hdr_mem[int'(icer_pkg::POS_DST_IP) + i] = t;
						end
						hdr_mem[icer_pkg::POS_TYPE] = icer_pkg::ECHO_REP_TYPE;
						cs = {hdr_mem[icer_pkg::POS_CSUM_HI], hdr_mem[icer_pkg::POS_CSUM_LO]};
						cs = ~oc_sum(oc_sum(~cs, ~icer_pkg::ECHO_REQUEST_WORD),
						             icer_pkg::ECHO_REPLY_WORD);
						hdr_mem[icer_pkg::POS_CSUM_HI] = cs[15:8];
						hdr_mem[icer_pkg::POS_CSUM_LO] = cs[7:0];
						for (int i = 0; i < int'(icer_pkg::HDR_LEN); i++) begin
							push_reply(hdr_mem[i], last && (i == icer_pkg::HDR_LEN - 1), 1'b0);
						end
						frame_state = last ? icer_pkg::MODE_COLLECT : icer_pkg::MODE_PASS;
					end
				end
			end
		endcase
	endfunction

	// Predict from each accepted input item first, then check each accepted result
	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_reply(in_ch.in_byte, in_ch.in_last);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (reply_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, byte %02h last %b dropped %b", $time,
						out_ch.out_byte, out_ch.out_last, out_ch.frame_dropped);
				end else begin
					exp_r = reply_q.pop_front();
					if (out_ch.out_byte !== exp_r.data) begin
						err_count++;
						$display("%0t: out_byte expected %02h, got %02h", $time,
							exp_r.data, out_ch.out_byte);
					end
					if (out_ch.out_last !== exp_r.last) begin
						err_count++;
						$display("%0t: out_last expected %b, got %b", $time,
							exp_r.last, out_ch.out_last);
					end
					if (out_ch.frame_dropped !== exp_r.drop) begin
						err_count++;
						$display("%0t: frame_dropped expected %b, got %b", $time,
							exp_r.drop, out_ch.frame_dropped);
					end
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Offer one item, with random idle cycles ahead of it; return once accepted
	task automatic push_byte(input icer_pkg::byte_t b, input logic last);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
	endtask

	task automatic send_frame(input icer_pkg::byte_t fr[$]);
		for (int i = 0; i < fr.size(); i++) begin
			push_byte(fr[i], i == fr.size() - 1);
		end
		sent_bytes += fr.size();
	endtask

	// Drop valid and hold until every expected result has come
	task automatic wait_replies_done();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Build a frame of the given kind with random content
	task automatic make_frame(input frame_kind_t kind, output icer_pkg::byte_t fr[$]);
		int unsigned     len;
		int unsigned     pay;
		icer_pkg::word_t cs;
		icer_pkg::byte_t v;
		fr = {};
		for (int i = 0; i < int'(icer_pkg::HDR_LEN); i++) begin
			fr.push_back(icer_pkg::byte_t'($urandom));
		end
		if (kind != FK_NOISE) begin
			fr[icer_pkg::POS_ETYPE_HI] = icer_pkg::ETH_P_IPV6_HI;
			fr[icer_pkg::POS_ETYPE_LO] = icer_pkg::ETH_P_IPV6_LO;
			fr[icer_pkg::POS_NEXTHDR]  = icer_pkg::NH_ICMP6;
			fr[icer_pkg::POS_TYPE]     = icer_pkg::ECHO_REQ_TYPE;
			// lean on checksum extremes now and then
			case ($urandom_range(5))
				0:       cs = 16'h0000;
				1:       cs = 16'hFFFF;
				2:       cs = 16'h7FFF;
				3:       cs = 16'h8000;
				default: cs = icer_pkg::word_t'($urandom);
			endcase
			fr[icer_pkg::POS_CSUM_HI] = cs[15:8];
			fr[icer_pkg::POS_CSUM_LO] = cs[7:0];
		end
		if (kind == FK_BAD_CHECK) begin
			case ($urandom_range(3))
				0: begin
					do v = icer_pkg::byte_t'($urandom); while (v == icer_pkg::ETH_P_IPV6_HI);
					fr[icer_pkg::POS_ETYPE_HI] = v;
				end
				1: begin
					do v = icer_pkg::byte_t'($urandom); while (v == icer_pkg::ETH_P_IPV6_LO);
					fr[icer_pkg::POS_ETYPE_LO] = v;
				end
				2: begin
					do v = icer_pkg::byte_t'($urandom); while (v == icer_pkg::NH_ICMP6);
					fr[icer_pkg::POS_NEXTHDR] = v;
				end
				default: begin
					if ($urandom_range(1) == 0) begin
						v = icer_pkg::ECHO_REP_TYPE;
					end else begin
						do v = icer_pkg::byte_t'($urandom); while (v == icer_pkg::ECHO_REQ_TYPE);
					end
					fr[icer_pkg::POS_TYPE] = v;
				end
			endcase
		end
		if (kind == FK_SHORT) begin
			// truncate before the header is complete
			if ($urandom_range(3) == 0) begin
				len = $urandom_range(13, icer_pkg::HDR_LEN - 1);
			end else begin
				len = $urandom_range(1, 12);
			end
			while (fr.size() > len) begin
				void'(fr.pop_back());
			end
		end else begin
			if ($urandom_range(2) == 0) begin
				pay = 0;
			end else if ($urandom_range(15) == 0) begin
				pay = $urandom_range(13, 30);
			end else begin
				pay = $urandom_range(1, 8);
			end
			for (int i = 0; i < int'(pay); i++) begin
				fr.push_back(icer_pkg::byte_t'($urandom));
			end
		end
	endtask

	// Directed: single-byte frames at both extremes and other short frames
	task automatic test_short_frames();
		icer_pkg::byte_t fr[$];
		fr = {8'h00};
		send_frame(fr);
		fr = {8'hFF};
		send_frame(fr);
		fr = {8'h01, 8'h80, 8'h7F};
		send_frame(fr);
		fr = {8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hC3};
		send_frame(fr);
		// IPv6 EtherType present but the frame ends right after it
		fr = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		      icer_pkg::ETH_P_IPV6_HI, icer_pkg::ETH_P_IPV6_LO};
		send_frame(fr);
	endtask

	// Random mix: mostly echo requests, some failed checks, short and noise frames
	task automatic test_random_frames(input int unsigned budget);
		int unsigned     start;
		int unsigned     r;
		frame_kind_t     kind;
		icer_pkg::byte_t fr[$];
		start = sent_bytes;
		while (sent_bytes - start < budget) begin
			r = $urandom_range(9);
			if (r < 6) begin
				kind = FK_ECHO;
			end else if (r < 8) begin
				kind = FK_BAD_CHECK;
			end else if (r == 8) begin
				kind = FK_SHORT;
			end else begin
				kind = FK_NOISE;
			end
			make_frame(kind, fr);
			send_frame(fr);
		end
	endtask

	// Hold the result side off while items keep coming, then pause until drained
	task automatic test_backpressure();
		icer_pkg::byte_t fr[$];
		in_idle_pct  = 0;
		out_idle_pct = 0;
		hold_req <= ~hold_req;
		make_frame(FK_ECHO, fr);
		send_frame(fr);
		make_frame(FK_SHORT, fr);
		send_frame(fr);
		wait_replies_done();
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles little, receiver a lot
		test_short_frames();
		test_random_frames(45);
		wait_replies_done();

		// the other way round
		in_idle_pct  = 84;
		out_idle_pct = 13;
		test_random_frames(45);
		wait_replies_done();

		// no idling at all
		in_idle_pct  = 0;
		out_idle_pct = 0;
		test_random_frames(45);
		test_backpressure();
		wait_replies_done();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && reply_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/icer_pkg.sv
rtl/icer_if.sv
rtl/icer_ram.sv
rtl/icmpv6_echo_responder_core.sv
rtl/icer_checker.sv
tb/tb.sv
